>>> hdl/ssuof_pkg.sv
// Shared types, codes and helpers of the stop string UTF-8 output filter.
package ssuof_pkg;

  // Queue depths between the parts of the block
  localparam int CMD_QUEUE_DEPTH = 2;
  localparam int RES_QUEUE_DEPTH = 4;

  // Configuration port data width
  localparam int CFG_DATA_W = 64;

  // Input operation codes
  localparam logic [1:0] OP_DATA    = 2'd0;
  localparam logic [1:0] OP_EOS     = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Result status codes
  localparam logic [2:0] STAT_RUN        = 3'd0;
  localparam logic [2:0] STAT_STOP       = 3'd1;
  localparam logic [2:0] STAT_BAD_LEAD   = 3'd2;
  localparam logic [2:0] STAT_BAD_CONT   = 3'd3;
  localparam logic [2:0] STAT_INCOMPLETE = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_TEXT_A = 3'd0;
  localparam logic [2:0] CFG_TEXT_B = 3'd1;
  localparam logic [2:0] CFG_TEXT_C = 3'd2;
  localparam logic [2:0] CFG_TEXT_D = 3'd3;
  localparam logic [2:0] CFG_LEN_A  = 3'd4;
  localparam logic [2:0] CFG_LEN_B  = 3'd5;
  localparam logic [2:0] CFG_LEN_C  = 3'd6;
  localparam logic [2:0] CFG_LEN_D  = 3'd7;

  // UTF-8 lead and continuation byte patterns
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] MASK_LEAD2  = 8'hE0;
  localparam logic [7:0] TAG_LEAD2   = 8'hC0;
  localparam logic [7:0] MASK_LEAD3  = 8'hF0;
  localparam logic [7:0] TAG_LEAD3   = 8'hE0;
  localparam logic [7:0] MASK_LEAD4  = 8'hF8;
  localparam logic [7:0] TAG_LEAD4   = 8'hF0;
  localparam logic [7:0] MASK_CONT   = 8'hC0;
  localparam logic [7:0] TAG_CONT    = 8'h80;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] status;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_DATA,
    CMD_EOS,
    CMD_RESTART
  } cmd_e;

  typedef struct packed {
    cmd_e       kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [2:0] width;
    logic       cont_ok;
  } cls_t;

  typedef enum logic [1:0] {
    MODE_DATA,
    MODE_STOP,
    MODE_EOS
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ANALYZE,
    S_MATCH,
    S_SCAN,
    S_RELEASE,
    S_TERM
  } state_e;

  // Character width from a lead byte, zero for a byte that cannot lead
  function automatic logic [2:0] utf8_width(input logic [7:0] b);
    logic [2:0] w;
    if (b < ASCII_LIMIT) begin
      w = 3'd1;
    end else if ((b & MASK_LEAD2) == TAG_LEAD2) begin
      w = 3'd2;
    end else if ((b & MASK_LEAD3) == TAG_LEAD3) begin
      w = 3'd3;
    end else if ((b & MASK_LEAD4) == TAG_LEAD4) begin
      w = 3'd4;
    end else begin
      w = 3'd0;
    end
    return w;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return (b & MASK_CONT) == TAG_CONT;
  endfunction

endpackage

>>> hdl/ssuof_fifo.sv
// Small register-based FIFO used between the parts of the filter.
module ssuof_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d;
  logic [PW-1:0]    rd_q, rd_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers with wrap and track fill level
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNTW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store entry data
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

>>> hdl/ssuof_front.sv
// Front end: accepts input transactions, classifies the operation and queues commands.
module ssuof_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ssuof_pkg::in_item_t  item_i,
  output logic                 full_o,
  output ssuof_pkg::cmd_t      cmd_o,
  output logic                 cmd_valid_o,
  input  logic                 cmd_pop_i
);

  localparam int CMDW = $bits(ssuof_pkg::cmd_t);

  ssuof_pkg::cmd_t cmd_w;
  logic            keep_w;
  logic            q_empty;
  logic [CMDW-1:0] q_rdata;

  // Classify the operation; drop the unused code here since it has no effect
  always_comb begin
    cmd_w.data = item_i.in_byte;
    keep_w     = 1'b1;
    case (item_i.op)
      ssuof_pkg::OP_DATA:    cmd_w.kind = ssuof_pkg::CMD_DATA;
      ssuof_pkg::OP_EOS:     cmd_w.kind = ssuof_pkg::CMD_EOS;
      ssuof_pkg::OP_RESTART: cmd_w.kind = ssuof_pkg::CMD_RESTART;
      default: begin
        cmd_w.kind = ssuof_pkg::CMD_DATA;
        keep_w     = 1'b0;
      end
    endcase
  end

  ssuof_fifo #(
    .WIDTH (CMDW),
    .DEPTH (ssuof_pkg::CMD_QUEUE_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i && keep_w),
    .wdata_i (cmd_w),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign cmd_o       = ssuof_pkg::cmd_t'(q_rdata);
  assign cmd_valid_o = !q_empty;

endmodule

>>> hdl/ssuof_back.sv
// Back end: pending buffer, stop and hold-tail matching, UTF-8 scan and byte release.
module ssuof_back #(
  parameter int NUM_STOPS     = 4,
  parameter int STOP_MAX_LEN  = 8,
  parameter int PENDING_DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [2:0]                       cfg_idx_i,
  input  logic [ssuof_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  ssuof_pkg::cmd_t                  cmd_i,
  input  logic                             cmd_valid_i,
  output logic                             cmd_pop_o,
  output ssuof_pkg::out_item_t             res_o,
  output logic                             res_push_o,
  input  logic                             res_full_i
);

  localparam int CW   = $clog2(PENDING_DEPTH + 1);
  localparam int IW   = $clog2(PENDING_DEPTH);
  localparam int SW   = CW + 1;
  localparam int TW   = 8 * STOP_MAX_LEN;
  localparam int CLSW = $bits(ssuof_pkg::cls_t);

  // Control state
  ssuof_pkg::state_e state_q, state_d;
  ssuof_pkg::mode_e  mode_q;
  logic [CW-1:0]     count_q;
  logic              fin_q;
  logic [CW-1:0]     idx_q;
  logic [CW-1:0]     limit_q;
  logic [CW-1:0]     rel_q;
  logic [2:0]        err_q;

  // Configuration
  logic [TW-1:0]     text_q [NUM_STOPS];
  logic [3:0]        len_q  [NUM_STOPS];
  logic [3:0]        n_w    [NUM_STOPS];

  // Payload
  logic [7:0]                 pend_q [PENDING_DEPTH];
  logic [PENDING_DEPTH-1:0]   hit_stop_q, hit_tail_q;
  logic [PENDING_DEPTH-1:0]   hit_stop_w, hit_tail_w;
  ssuof_pkg::cls_t            cls_q [PENDING_DEPTH];
  ssuof_pkg::cls_t            cls_w [PENDING_DEPTH];
  ssuof_pkg::cls_t            sc_q  [PENDING_DEPTH];

  wire [STOP_MAX_LEN:0]              pre_w  [NUM_STOPS][PENDING_DEPTH];
  wire [NUM_STOPS*PENDING_DEPTH-1:0] full_w, tail_w;
  wire [3:1]                         cbit_w [PENDING_DEPTH];
  wire [CLSW-1:0]                    shf_w  [PENDING_DEPTH][4];

  // Control strobes from the sequencer outputs and the scan step
  logic accept_data, accept_eos, do_restart;
  logic do_match, do_release, do_term;
  logic scan_ok, scan_err, scan_adv;
  logic [2:0] scan_code;

  // Match results
  logic          stop_any, tail_any;
  logic [IW-1:0] stop_pos, tail_pos;
  logic [CW-1:0] limit_w;

  logic [2:0]    sc_width;
  logic [1:0]    sc_sel;
  logic [SW-1:0] sc_end;

  // Clamp stop lengths to the supported maximum
  always_comb begin
    for (int s = 0; s < NUM_STOPS; s++) begin
      n_w[s] = (len_q[s] > 4'(STOP_MAX_LEN)) ? 4'(STOP_MAX_LEN) : len_q[s];
    end
  end

  // Compare every buffer window against every stop string
  for (genvar s = 0; s < NUM_STOPS; s++) begin : g_stop
    for (genvar b = 0; b < PENDING_DEPTH; b++) begin : g_pos
      wire [STOP_MAX_LEN:1] fl_w, tl_w;
      assign pre_w[s][b][0] = 1'b1;
      for (genvar i = 0; i < STOP_MAX_LEN; i++) begin : g_byte
        if (b + i < PENDING_DEPTH) begin : g_in
          assign pre_w[s][b][i+1] = pre_w[s][b][i] &&
                                    (pend_q[b+i] == text_q[s][8*i +: 8]);
        end else begin : g_out
          assign pre_w[s][b][i+1] = 1'b0;
        end
      end
      for (genvar l = 1; l <= STOP_MAX_LEN; l++) begin : g_len
        // full match of length l starting at b, inside the filled part
        assign fl_w[l] = (n_w[s] == 4'(l)) && pre_w[s][b][l] &&
                         (SW'(b + l) <= SW'(count_q));
        // buffer tail from b is a proper prefix of this stop
        assign tl_w[l] = (4'(l) < n_w[s]) && pre_w[s][b][l] &&
                         (SW'(b + l) == SW'(count_q));
      end
      assign full_w[s*PENDING_DEPTH + b] = |fl_w;
      assign tail_w[s*PENDING_DEPTH + b] = |tl_w;
    end
  end

  always_comb begin
    hit_stop_w = '0;
    hit_tail_w = '0;
    for (int s = 0; s < NUM_STOPS; s++) begin
      hit_stop_w = hit_stop_w | full_w[s*PENDING_DEPTH +: PENDING_DEPTH];
      hit_tail_w = hit_tail_w | tail_w[s*PENDING_DEPTH +: PENDING_DEPTH];
    end
  end

  // Classify each buffer position as a character start
  for (genvar b = 0; b < PENDING_DEPTH; b++) begin : g_cls
    for (genvar o = 1; o <= 3; o++) begin : g_cont
      if (b + o < PENDING_DEPTH) begin : g_in
        assign cbit_w[b][o] = ssuof_pkg::is_cont(pend_q[b+o]);
      end else begin : g_out
        assign cbit_w[b][o] = 1'b0;
      end
    end
  end

  always_comb begin
    for (int b = 0; b < PENDING_DEPTH; b++) begin
      cls_w[b].width   = ssuof_pkg::utf8_width(pend_q[b]);
      cls_w[b].cont_ok = (cls_w[b].width < 3'd2 || cbit_w[b][1]) &&
                         (cls_w[b].width < 3'd3 || cbit_w[b][2]) &&
                         (cls_w[b].width < 3'd4 || cbit_w[b][3]);
    end
  end

  // Shifted copies of the scan line, one per character width
  for (genvar j = 0; j < PENDING_DEPTH; j++) begin : g_shf
    for (genvar k = 1; k <= 4; k++) begin : g_by
      if (j + k < PENDING_DEPTH) begin : g_in
        assign shf_w[j][k-1] = sc_q[j+k];
      end else begin : g_out
        assign shf_w[j][k-1] = '0;
      end
    end
  end

  // Pick the earliest stop start and the earliest held-tail start
  always_comb begin
    stop_any = 1'b0;
    tail_any = 1'b0;
    stop_pos = '0;
    tail_pos = '0;
    for (int b = PENDING_DEPTH - 1; b >= 0; b--) begin
      if (hit_stop_q[b]) begin
        stop_any = 1'b1;
        stop_pos = IW'(b);
      end
      if (hit_tail_q[b]) begin
        tail_any = 1'b1;
        tail_pos = IW'(b);
      end
    end
    if (mode_q == ssuof_pkg::MODE_EOS) begin
      limit_w = count_q;
    end else if (stop_any) begin
      limit_w = CW'(stop_pos);
    end else if (tail_any) begin
      limit_w = CW'(tail_pos);
    end else begin
      limit_w = count_q;
    end
  end

  // Step the UTF-8 scan by one character
  always_comb begin
    sc_width  = sc_q[0].width;
    sc_sel    = 2'(sc_width - 3'd1);
    sc_end    = SW'(idx_q) + SW'(sc_width);
    scan_ok   = 1'b0;
    scan_err  = 1'b0;
    scan_adv  = 1'b0;
    scan_code = ssuof_pkg::STAT_RUN;
    if (state_q == ssuof_pkg::S_SCAN) begin
      if (idx_q >= limit_q) begin
        scan_ok = 1'b1;
      end else if (sc_width == 3'd0) begin
        scan_err  = 1'b1;
        scan_code = ssuof_pkg::STAT_BAD_LEAD;
      end else if (sc_end > SW'(limit_q)) begin
        scan_ok = 1'b1;
      end else if (!sc_q[0].cont_ok) begin
        scan_err  = 1'b1;
        scan_code = ssuof_pkg::STAT_BAD_CONT;
      end else begin
        scan_adv = 1'b1;
      end
    end
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ssuof_pkg::S_IDLE: begin
        if (accept_data || accept_eos) begin
          state_d = ssuof_pkg::S_ANALYZE;
        end
      end
      ssuof_pkg::S_ANALYZE: state_d = ssuof_pkg::S_MATCH;
      ssuof_pkg::S_MATCH:   state_d = ssuof_pkg::S_SCAN;
      ssuof_pkg::S_SCAN: begin
        if (scan_ok) begin
          if (idx_q != '0) begin
            state_d = ssuof_pkg::S_RELEASE;
          end else if (mode_q == ssuof_pkg::MODE_DATA) begin
            state_d = ssuof_pkg::S_IDLE;
          end else begin
            state_d = ssuof_pkg::S_TERM;
          end
        end else if (scan_err) begin
          state_d = ssuof_pkg::S_TERM;
        end
      end
      ssuof_pkg::S_RELEASE: begin
        if (!res_full_i && rel_q == CW'(1)) begin
          state_d = (mode_q == ssuof_pkg::MODE_DATA) ? ssuof_pkg::S_IDLE
                                                      : ssuof_pkg::S_TERM;
        end
      end
      ssuof_pkg::S_TERM: begin
        if (!res_full_i) begin
          state_d = ssuof_pkg::S_IDLE;
        end
      end
      default: state_d = ssuof_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    cmd_pop_o      = 1'b0;
    accept_data    = 1'b0;
    accept_eos     = 1'b0;
    do_restart     = 1'b0;
    do_match       = 1'b0;
    do_release     = 1'b0;
    do_term        = 1'b0;
    res_push_o     = 1'b0;
    res_o.out_byte   = 8'h00;
    res_o.byte_valid = 1'b0;
    res_o.status     = ssuof_pkg::STAT_RUN;
    res_o.last       = 1'b0;
    case (state_q)
      ssuof_pkg::S_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            ssuof_pkg::CMD_DATA:
              accept_data = !fin_q && (count_q < CW'(PENDING_DEPTH));
            ssuof_pkg::CMD_EOS:
              accept_eos = !fin_q;
            ssuof_pkg::CMD_RESTART:
              do_restart = 1'b1;
            default: ;
          endcase
        end
      end
      ssuof_pkg::S_MATCH: do_match = 1'b1;
      ssuof_pkg::S_RELEASE: begin
        do_release       = !res_full_i;
        res_push_o       = !res_full_i;
        res_o.out_byte   = pend_q[0];
        res_o.byte_valid = 1'b1;
        res_o.last       = (mode_q == ssuof_pkg::MODE_DATA) && (rel_q == CW'(1));
      end
      ssuof_pkg::S_TERM: begin
        do_term    = !res_full_i;
        res_push_o = !res_full_i;
        res_o.last = 1'b1;
        if (err_q != ssuof_pkg::STAT_RUN) begin
          res_o.status = err_q;
        end else if (mode_q == ssuof_pkg::MODE_STOP) begin
          res_o.status = ssuof_pkg::STAT_STOP;
        end else if (count_q != '0) begin
          res_o.status = ssuof_pkg::STAT_INCOMPLETE;
        end else begin
          res_o.status = ssuof_pkg::STAT_RUN;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssuof_pkg::S_IDLE;
      mode_q  <= ssuof_pkg::MODE_DATA;
      count_q <= '0;
      fin_q   <= 1'b0;
      idx_q   <= '0;
      limit_q <= '0;
      rel_q   <= '0;
      err_q   <= ssuof_pkg::STAT_RUN;
    end else begin
      state_q <= state_d;
      if (do_restart) begin
        count_q <= '0;
        fin_q   <= 1'b0;
      end
      if (accept_data) begin
        count_q <= count_q + CW'(1);
        mode_q  <= ssuof_pkg::MODE_DATA;
      end
      if (accept_eos) begin
        mode_q <= ssuof_pkg::MODE_EOS;
      end
      if (do_match) begin
        limit_q <= limit_w;
        idx_q   <= '0;
        err_q   <= ssuof_pkg::STAT_RUN;
        if (mode_q != ssuof_pkg::MODE_EOS && stop_any) begin
          mode_q <= ssuof_pkg::MODE_STOP;
        end
      end
      if (scan_adv) begin
        idx_q <= idx_q + CW'(sc_width);
      end
      if (scan_ok) begin
        rel_q <= idx_q;
      end
      if (scan_err) begin
        err_q <= scan_code;
      end
      if (do_release) begin
        count_q <= count_q - CW'(1);
        rel_q   <= rel_q - CW'(1);
      end
      if (do_term) begin
        fin_q <= 1'b1;
      end
    end
  end

  // Stop string registers
  for (genvar s = 0; s < NUM_STOPS; s++) begin : g_cfg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        text_q[s] <= '0;
        len_q[s]  <= '0;
      end else if (cfg_we_i) begin
        if (cfg_idx_i == ssuof_pkg::CFG_TEXT_A + 3'(s)) begin
          text_q[s] <= cfg_data_i[TW-1:0];
        end
        if (cfg_idx_i == ssuof_pkg::CFG_LEN_A + 3'(s)) begin
          len_q[s] <= cfg_data_i[3:0];
        end
      end
    end
  end

  // Pending buffer: append at the fill point, shift out from the front
  always_ff @(posedge clk_i) begin
    if (accept_data) begin
      pend_q[count_q[IW-1:0]] <= cmd_i.data;
    end
    if (do_release) begin
      for (int j = 0; j < PENDING_DEPTH - 1; j++) begin
        pend_q[j] <= pend_q[j+1];
      end
    end
  end

  // Register match vectors and character classes, and run the scan line
  always_ff @(posedge clk_i) begin
    hit_stop_q <= hit_stop_w;
    hit_tail_q <= hit_tail_w;
    cls_q      <= cls_w;
    if (do_match) begin
      sc_q <= cls_q;
    end else if (scan_adv) begin
      for (int j = 0; j < PENDING_DEPTH; j++) begin
        sc_q[j] <= ssuof_pkg::cls_t'(shf_w[j][sc_sel]);
      end
    end
  end

endmodule

>>> hdl/stop_string_utf8_output_filter.sv
// Top level of the stop string UTF-8 output filter.
// Sequence: the back end pops a command in its idle state, then steps through analyze, match
// and a UTF-8 scan that steps over whole characters, then releases bytes from the buffer head,
// one per cycle while the result queue is not full; it pops no new command until it is idle
// again.
// Reset: clears queues, fill count, finished flag and stop registers; buffer bytes are kept.
module stop_string_utf8_output_filter #(
  parameter int NUM_STOPS     = 4,
  parameter int STOP_MAX_LEN  = 8,
  parameter int PENDING_DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  input  ssuof_pkg::in_item_t              in_item_i,
  output logic                             full,
  output logic                             empty,
  input  logic                             pop,
  output ssuof_pkg::out_item_t             res_item_o,
  input  logic                             cfg_we_i,
  input  logic [2:0]                       cfg_idx_i,
  input  logic [ssuof_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int RESW = $bits(ssuof_pkg::out_item_t);

  ssuof_pkg::cmd_t      cmd;
  logic                 cmd_valid;
  logic                 cmd_pop;
  ssuof_pkg::out_item_t res;
  logic                 res_push;
  logic                 res_full;
  logic [RESW-1:0]      res_rdata;

  // Accept and classify input transactions
  ssuof_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (in_item_i),
    .full_o      (full),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  // Match, validate and release
  ssuof_back #(
    .NUM_STOPS     (NUM_STOPS),
    .STOP_MAX_LEN  (STOP_MAX_LEN),
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // Hold results until the consumer takes them
  ssuof_fifo #(
    .WIDTH (RESW),
    .DEPTH (ssuof_pkg::RES_QUEUE_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign res_item_o = ssuof_pkg::out_item_t'(res_rdata);

endmodule

>>> tb/sv/tb_stop_string_utf8_output_filter.sv
// Self-checking testbench of the stop string UTF-8 output filter, with its own predictor.
module tb_stop_string_utf8_output_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import ssuof_pkg::*;

  localparam int PEND_DEPTH    = 16;
  localparam int MAX_STOP_LEN  = 8;
  localparam int TAIL_WAIT     = 64;
  localparam int RANDOM_ITEMS  = 450;
  localparam int PHASES        = 8;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [1:0] OP_SPARE = 2'd3;

  // Predicts the released bytes and terminal codes, and checks the result stream
  class filter_scoreboard;
    logic [63:0] stop_text [4];
    logic [3:0]  stop_len [4];
    logic [7:0]  held [PEND_DEPTH];
    int unsigned held_cnt;
    bit          stream_done;
    out_item_t   expected_q [$];
    int unsigned n_checked;
    int unsigned n_errors;

    function new();
      for (int s = 0; s < 4; s++) begin
        stop_text[s] = '0;
        stop_len[s]  = '0;
      end
      for (int i = 0; i < PEND_DEPTH; i++) held[i] = '0;
      held_cnt    = 0;
      stream_done = 1'b0;
      n_checked   = 0;
      n_errors    = 0;
    endfunction

    function void note_config(logic [2:0] idx, logic [63:0] data);
      case (idx)
        CFG_TEXT_A: stop_text[0] = data;
        CFG_TEXT_B: stop_text[1] = data;
        CFG_TEXT_C: stop_text[2] = data;
        CFG_TEXT_D: stop_text[3] = data;
        CFG_LEN_A:  stop_len[0]  = data[3:0];
        CFG_LEN_B:  stop_len[1]  = data[3:0];
        CFG_LEN_C:  stop_len[2]  = data[3:0];
        CFG_LEN_D:  stop_len[3]  = data[3:0];
        default: ;
      endcase
    endfunction

    // Clamp a stop length to the longest supported string
    function int unsigned used_len(int s);
      int unsigned n;
      n = stop_len[s];
      if (n > MAX_STOP_LEN) n = MAX_STOP_LEN;
      return n;
    endfunction

    function logic [7:0] stop_char(int s, int unsigned i);
      return stop_text[s][8*i +: 8];
    endfunction

    // Find the earliest start of a complete stop string, held_cnt if none
    function int unsigned first_stop_start();
      int unsigned best, n, i;
      best = held_cnt;
      for (int s = 0; s < 4; s++) begin
        n = used_len(s);
        if (n == 0 || n > held_cnt) continue;
        for (int unsigned p = 0; p + n <= held_cnt && p < best; p++) begin
          i = 0;
          while (i < n && held[p + i] == stop_char(s, i)) i++;
          if (i == n) begin
            best = p;
            break;
          end
        end
      end
      return best;
    endfunction

    // Longest tail that could still grow into a stop string
    function int unsigned tail_hold();
      int unsigned keep, n, k, i;
      keep = 0;
      for (int s = 0; s < 4; s++) begin
        n = used_len(s);
        if (n == 0) continue;
        k = (n - 1 > held_cnt) ? held_cnt : n - 1;
        while (k > 0) begin
          i = 0;
          while (i < k && held[held_cnt - k + i] == stop_char(s, i)) i++;
          if (i == k) begin
            if (k > keep) keep = k;
            break;
          end
          k--;
        end
      end
      return keep;
    endfunction

    function int unsigned lead_width(logic [7:0] b);
      if (b < ASCII_LIMIT) return 1;
      if ((b & MASK_LEAD2) == TAG_LEAD2) return 2;
      if ((b & MASK_LEAD3) == TAG_LEAD3) return 3;
      if ((b & MASK_LEAD4) == TAG_LEAD4) return 4;
      return 0;
    endfunction

    // Count the bytes of whole, valid characters in front of limit
    function int unsigned whole_chars(int unsigned limit, output logic [2:0] err);
      int unsigned pos, w;
      pos = 0;
      err = STAT_RUN;
      while (pos < limit) begin
        w = lead_width(held[pos]);
        if (w == 0) begin
          err = STAT_BAD_LEAD;
          return 0;
        end
        if (pos + w > limit) break;
        for (int unsigned o = 1; o < w; o++) begin
          if ((held[pos + o] & MASK_CONT) != TAG_CONT) begin
            err = STAT_BAD_CONT;
            return 0;
          end
        end
        pos += w;
      end
      return pos;
    endfunction

    function void add_result(logic [7:0] b, logic v, logic [2:0] st, logic lst);
      out_item_t r;
      r.out_byte   = b;
      r.byte_valid = v;
      r.status     = st;
      r.last       = lst;
      expected_q.insert(expected_q.size(), r);
    endfunction

    // Emit the first n held bytes and shift the rest down
    function void release_head(int unsigned n);
      for (int unsigned i = 0; i < n; i++) add_result(held[i], 1'b1, STAT_RUN, 1'b0);
      for (int unsigned i = n; i < held_cnt; i++) held[i - n] = held[i];
      held_cnt -= n;
    endfunction

    // Predict the results of one accepted transaction; returns 0 if it is ignored
    function bit note_input(in_item_t it);
      int unsigned limit, n;
      logic [2:0] err;
      if (it.op == OP_RESTART) begin
        held_cnt    = 0;
        stream_done = 1'b0;
        return 1'b1;
      end
      if (it.op == OP_SPARE || stream_done) return 1'b0;
      if (it.op == OP_DATA) begin
        if (held_cnt >= PEND_DEPTH) return 1'b0;
        held[held_cnt] = it.in_byte;
        held_cnt++;
        // Stop string complete: release what stands in front of it and finish
        limit = first_stop_start();
        if (limit < held_cnt) begin
          n = whole_chars(limit, err);
          if (err == STAT_RUN) begin
            release_head(n);
            err = STAT_STOP;
          end
          add_result(8'h00, 1'b0, err, 1'b1);
          stream_done = 1'b1;
          return 1'b1;
        end
        // Hold a possible stop prefix, release whole characters before it
        n = whole_chars(held_cnt - tail_hold(), err);
        if (err != STAT_RUN) begin
          add_result(8'h00, 1'b0, err, 1'b1);
          stream_done = 1'b1;
          return 1'b1;
        end
        if (n > 0) begin
          release_head(n);
          expected_q[expected_q.size() - 1].last = 1'b1;
        end
        return 1'b1;
      end
      // End of stream: flush whole characters, flag a leftover fragment
      n = whole_chars(held_cnt, err);
      if (err == STAT_RUN) begin
        release_head(n);
        err = (held_cnt != 0) ? STAT_INCOMPLETE : STAT_RUN;
      end
      add_result(8'h00, 1'b0, err, 1'b1);
      stream_done = 1'b1;
      return 1'b1;
    endfunction

    // Compare one popped result with the oldest prediction
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= REPORT_LIMIT)
          $display("unexpected result: byte %02h valid %0b status %0d last %0b",
                   got.out_byte, got.byte_valid, got.status, got.last);
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
          got.status !== want.status || got.last !== want.last) begin
        n_errors++;
        if (n_errors <= REPORT_LIMIT)
          $display({"result %0d: expected byte %02h valid %0b status %0d last %0b,",
                    " got byte %02h valid %0b status %0d last %0b"},
                   n_checked, want.out_byte, want.byte_valid, want.status, want.last,
                   got.out_byte, got.byte_valid, got.status, got.last);
      end
    endfunction
  endclass

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b1;
  logic                  push     = 1'b0;
  in_item_t              in_item  = '0;
  logic                  full;
  logic                  empty;
  logic                  pop      = 1'b0;
  out_item_t             res_item;
  logic                  cfg_we   = 1'b0;
  logic [2:0]            cfg_idx  = CFG_TEXT_A;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [63:0] stop_text_set [4];
  logic [3:0]  stop_len_set [4];
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int unsigned pushes         = 0;
  int unsigned items_counted  = 0;

  filter_scoreboard sb = new();

  stop_string_utf8_output_filter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_item_i  (in_item),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .res_item_o (res_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Pop results with random stalls and check each accepted one
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) sb.check_result(res_item);
      pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Push one transaction after a random gap, then hold until accepted
  task automatic send_item(logic [1:0] op, logic [7:0] b);
    in_item_t it;
    it.op      = op;
    it.in_byte = b;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pushes++;
    if (sb.note_input(it)) items_counted++;
  endtask

  // Stop pushing until every predicted result has been popped
  task automatic wait_results(int unsigned extra);
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // Write all eight stop registers from the current setting
  task automatic program_stops();
    for (int s = 0; s < 4; s++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= CFG_TEXT_A + 3'(s);
      cfg_data <= stop_text_set[s];
      @(posedge clk_i);
      sb.note_config(CFG_TEXT_A + 3'(s), stop_text_set[s]);
    end
    for (int s = 0; s < 4; s++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= CFG_LEN_A + 3'(s);
      cfg_data <= 64'(stop_len_set[s]);
      @(posedge clk_i);
      sb.note_config(CFG_LEN_A + 3'(s), 64'(stop_len_set[s]));
    end
    cfg_we <= 1'b0;
  endtask

  // Bias bytes toward a tiny alphabet so stop prefixes collide often
  function automatic logic [7:0] rand_text_byte();
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return 8'h61 + 8'($urandom_range(0, 3));
  endfunction

  function automatic logic [7:0] rand_ascii();
    if ($urandom_range(0, 1) == 0) return 8'h61 + 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, 127));
  endfunction

  // Pick the stop strings of one phase, extremes first
  task automatic choose_setting(int p);
    for (int s = 0; s < 4; s++) begin
      stop_text_set[s] = '0;
      for (int i = 0; i < 8; i++) stop_text_set[s][8*i +: 8] = rand_text_byte();
      stop_len_set[s] = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                     : 4'($urandom_range(1, 8));
    end
    case (p)
      0: begin
        stop_text_set[0] = 64'h0000_0000_0044_4E45;  // "END"
        stop_len_set[0]  = 4'd3;
        stop_text_set[1] = 64'h0000_0000_0000_0A0A;  // two newlines
        stop_len_set[1]  = 4'd2;
        stop_text_set[2] = 64'h0000_0000_00A6_80E2;  // three-byte ellipsis
        stop_len_set[2]  = 4'd3;
        stop_text_set[3] = '1;
        stop_len_set[3]  = 4'd8;
      end
      1: for (int s = 0; s < 4; s++) stop_len_set[s] = 4'd0;
      2: for (int s = 0; s < 4; s++) begin
        stop_text_set[s] = '1;
        stop_len_set[s]  = 4'hF;
      end
      3: for (int s = 0; s < 4; s++) begin
        stop_text_set[s] = '0;
        stop_len_set[s]  = 4'd8;
      end
      4: begin
        stop_text_set[0] = 64'h61;
        stop_len_set[0]  = 4'd1;
        for (int s = 1; s < 4; s++) stop_len_set[s] = 4'd0;
      end
      default: ;
    endcase
  endtask

  // Short hand-picked sequence: each terminal code and the ignore rules
  task automatic run_directed();
    send_item(OP_DATA, 8'h7F);
    send_item(OP_DATA, 8'hC3);
    send_item(OP_DATA, 8'hA9);
    send_item(OP_DATA, 8'h45);  // held as stop prefix
    send_item(OP_DATA, 8'h4E);
    send_item(OP_DATA, 8'h78);  // breaks the prefix, releases three bytes
    send_item(OP_DATA, 8'h61);
    send_item(OP_DATA, 8'hE2);
    send_item(OP_DATA, 8'h80);
    send_item(OP_DATA, 8'hA6);  // multibyte stop completes
    send_item(OP_DATA, 8'h71);  // ignored after finish
    send_item(OP_EOS, 8'hFF);
    send_item(OP_SPARE, 8'h00);
    send_item(OP_RESTART, 8'h5A);
    send_item(OP_DATA, 8'h80);  // stray continuation as lead
    send_item(OP_RESTART, 8'hA5);
    send_item(OP_DATA, 8'hC3);
    send_item(OP_DATA, 8'h41);  // bad continuation
    send_item(OP_RESTART, 8'h00);
    send_item(OP_DATA, 8'hF0);
    send_item(OP_EOS, 8'h00);   // unfinished character at end
    send_item(OP_RESTART, 8'hFF);
    send_item(OP_DATA, 8'h61);
    send_item(OP_EOS, 8'h00);   // clean end of stream
    send_item(OP_RESTART, 8'h00);
  endtask

  // Push one character, stop fragment or piece of noise
  task automatic send_char();
    int kind, s, n, m, w;
    logic [7:0] lead;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      send_item(OP_DATA, rand_ascii());
    end else if (kind < 55) begin
      w = $urandom_range(2, 4);
      case (w)
        2: lead = TAG_LEAD2 | 8'($urandom_range(0, 31));
        3: lead = TAG_LEAD3 | 8'($urandom_range(0, 15));
        default: lead = TAG_LEAD4 | 8'($urandom_range(0, 7));
      endcase
      send_item(OP_DATA, lead);
      for (int i = 1; i < w; i++) send_item(OP_DATA, TAG_CONT | 8'($urandom_range(0, 63)));
    end else if (kind < 85) begin
      s = $urandom_range(0, 3);
      n = (stop_len_set[s] > MAX_STOP_LEN) ? MAX_STOP_LEN : stop_len_set[s];
      if (n == 0) begin
        send_item(OP_DATA, rand_ascii());
      end else begin
        m = ($urandom_range(0, 2) == 0) ? n : $urandom_range(1, n);
        for (int i = 0; i < m; i++) send_item(OP_DATA, stop_text_set[s][8*i +: 8]);
      end
    end else if (kind < 93) begin
      send_item(OP_DATA, 8'($urandom));
    end else if (kind < 96) begin
      // Broken character: lone continuation or a lead cut short
      if ($urandom_range(0, 1) == 0) begin
        send_item(OP_DATA, TAG_CONT | 8'($urandom_range(0, 63)));
      end else begin
        send_item(OP_DATA, TAG_LEAD3 | 8'($urandom_range(0, 15)));
        send_item(OP_DATA, rand_ascii());
      end
    end else if (kind < 98) begin
      send_item(OP_SPARE, 8'($urandom));
    end else begin
      send_item(OP_RESTART, 8'($urandom));
    end
  endtask

  // One text stream: characters until a stop or an error, then usually an end, then a restart
  task automatic send_stream();
    int chars;
    chars = $urandom_range(1, 12);
    for (int c = 0; c < chars && !sb.stream_done; c++) send_char();
    if (sb.stream_done && $urandom_range(0, 9) == 0)
      send_item(($urandom_range(0, 1) == 0) ? OP_DATA : OP_EOS, 8'($urandom));
    if (!sb.stream_done && $urandom_range(0, 3) != 0) send_item(OP_EOS, 8'($urandom));
    send_item(OP_RESTART, 8'($urandom));
  endtask

  // Main sequence: reset, then one phase per stop setting
  initial begin
    int unsigned target, mid;
    bit paused;
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      wait_results(TAIL_WAIT);
      choose_setting(p);
      program_stops();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      if (p == 0) run_directed();
      target = items_counted + RANDOM_ITEMS / PHASES;
      mid    = items_counted + RANDOM_ITEMS / (2 * PHASES);
      paused = 1'b0;
      while (items_counted < target) begin
        send_stream();
        if (!paused && items_counted >= mid) begin
          wait_results(0);
          paused = 1'b1;
        end
      end
    end
    wait_results(TAIL_WAIT);
    $display("covered %0d transactions (%0d acted on) over %0d stop settings",
             pushes, items_counted, PHASES);
    $display("and four idle modes; %0d results compared, %0d failures",
             sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> stop_string_utf8_output_filter.f
hdl/ssuof_pkg.sv
hdl/ssuof_fifo.sv
hdl/ssuof_front.sv
hdl/ssuof_back.sv
hdl/stop_string_utf8_output_filter.sv
tb/sv/tb_stop_string_utf8_output_filter.sv
